FILE: rtl/core/wrol_pkg.sv
// wrol_pkg: shared widths, request codes and sequencer state type for the
// write ring offset lookup block. No dependencies.
`timescale 1ns / 1ps

package wrol_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TAG_W     = 32;
	localparam int LEN_W     = 16;
	localparam int OFF_W     = 20;
	localparam int HIDX_W    = 4;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_FIND = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

endpackage

FILE: rtl/core/write_ring_offset_lookup.sv
// write_ring_offset_lookup: overwriting ring of tag/length slots with a
// sequential byte-offset lookup walk. Depends on wrol_pkg.
`timescale 1ns / 1ps

// channel | handshake            | payload
// in      | in_valid / in_ready  | req_type, entry_tag, entry_size, byte_pos
// out     | out_valid / out_ready| found, hit_index, hit_tag, hit_size, byte_within, ring_full
//
// Add: result beat registered at accept, valid in the next cycle.
// Find: the first slot is read at accept, then the walk checks one slot per cycle
//   through the length/tag memory read port, up to SLOTS slots, until the result beat.
// Reset clears pointers, full flag and per-slot valid bits; no clearing pass.
// in_ready is low during a walk and while an unaccepted result beat is held.
module write_ring_offset_lookup #(
	parameter int SLOTS = wrol_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [wrol_pkg::TAG_W-1:0]  entry_tag,
	input  logic [wrol_pkg::LEN_W-1:0]  entry_size,
	input  logic [wrol_pkg::OFF_W-1:0]  byte_pos,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [wrol_pkg::HIDX_W-1:0] hit_index,
	output logic [wrol_pkg::TAG_W-1:0]  hit_tag,
	output logic [wrol_pkg::LEN_W-1:0]  hit_size,
	output logic [wrol_pkg::LEN_W-1:0]  byte_within,
	output logic                        ring_full
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	wrol_pkg::state_t state_q;

	logic [wrol_pkg::LEN_W-1:0] len_mem [SLOTS];
	logic [wrol_pkg::TAG_W-1:0] tag_mem [SLOTS];
	logic [SLOTS-1:0]           vld_q;

	logic [IW-1:0]              wr_ptr_q, rd_ptr_q, cur_q, cnt_q;
	logic                       full_q;
	logic [wrol_pkg::OFF_W-1:0] off_q;
	logic [wrol_pkg::LEN_W-1:0] len_rd_q;
	logic [wrol_pkg::TAG_W-1:0] tag_rd_q;
	logic                       vld_rd_q;

	logic                       out_valid_q, found_q, full_out_q;
	logic [wrol_pkg::HIDX_W-1:0] hidx_q;
	logic [wrol_pkg::TAG_W-1:0] htag_q;
	logic [wrol_pkg::LEN_W-1:0] hsize_q, within_q;

	logic                       out_free, acc, add_acc, find_acc;
	logic [IW-1:0]              rd_idx, wr_nxt;
	logic [wrol_pkg::LEN_W-1:0] len_eff;
	logic [wrol_pkg::OFF_W-1:0] len_ext;
	logic                       skip;
	logic [IW+3:0]              idx_ext;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == wrol_pkg::ST_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign add_acc  = acc && (req_type == wrol_pkg::REQ_ADD);
	assign find_acc = acc && (req_type == wrol_pkg::REQ_FIND);

	assign rd_idx  = (state_q == wrol_pkg::ST_WALK) ? next_slot(cur_q) : rd_ptr_q;
	assign wr_nxt  = next_slot(wr_ptr_q);
	assign len_eff = vld_rd_q ? len_rd_q : '0;
	assign len_ext = wrol_pkg::OFF_W'(len_eff);
	assign skip    = off_q >= len_ext;
	assign idx_ext = {{4{1'b0}}, cur_q};

	// slot memories
	always_ff @(posedge clk) begin
		if (add_acc) begin
			len_mem[wr_ptr_q] <= entry_size;
			tag_mem[wr_ptr_q] <= entry_tag;
		end
		len_rd_q <= len_mem[rd_idx];
		tag_rd_q <= tag_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (acc)
			off_q <= byte_pos;
		else if (state_q == wrol_pkg::ST_WALK && skip)
			off_q <= off_q - len_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wrol_pkg::ST_IDLE;
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			full_q      <= 1'b0;
			cur_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			full_out_q  <= 1'b0;
			hidx_q      <= '0;
			htag_q      <= '0;
			hsize_q     <= '0;
			within_q    <= '0;
		end else begin
			vld_rd_q <= vld_q[rd_idx];
			if (out_valid_q && out_ready && !add_acc)
				out_valid_q <= 1'b0;
			unique case (state_q)
				wrol_pkg::ST_IDLE: begin
					if (add_acc) begin
						vld_q[wr_ptr_q] <= 1'b1;
						wr_ptr_q        <= wr_nxt;
						if (full_q)
							rd_ptr_q <= next_slot(rd_ptr_q);
						else if (wr_nxt == rd_ptr_q)
							full_q <= 1'b1;
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						hidx_q      <= '0;
						htag_q      <= '0;
						hsize_q     <= '0;
						within_q    <= '0;
						full_out_q  <= full_q || (wr_nxt == rd_ptr_q);
					end else if (find_acc) begin
						cur_q   <= rd_ptr_q;
						cnt_q   <= '0;
						state_q <= wrol_pkg::ST_WALK;
					end
				end
				wrol_pkg::ST_WALK: begin
					if (len_eff != '0 && skip && cnt_q != LAST) begin
						cur_q <= next_slot(cur_q);
						cnt_q <= cnt_q + 1'b1;
					end else begin
						// zero-length slot, hit, or walked every slot
						state_q     <= wrol_pkg::ST_IDLE;
						out_valid_q <= 1'b1;
						full_out_q  <= full_q;
						if (len_eff != '0 && !skip) begin
							found_q  <= 1'b1;
							hidx_q   <= idx_ext[3:0];
							htag_q   <= tag_rd_q;
							hsize_q  <= len_eff;
							within_q <= off_q[wrol_pkg::LEN_W-1:0];
						end else begin
							found_q  <= 1'b0;
							hidx_q   <= '0;
							htag_q   <= '0;
							hsize_q  <= '0;
							within_q <= '0;
						end
					end
				end
				default: state_q <= wrol_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign hit_index   = hidx_q;
	assign hit_tag     = htag_q;
	assign hit_size    = hsize_q;
	assign byte_within = within_q;
	assign ring_full   = full_out_q;

endmodule

FILE: rtl/core/wrol_checker.sv
// wrol_checker: port-level assertions for write_ring_offset_lookup, bound
// to the top level below. Depends on wrol_pkg.
`timescale 1ns / 1ps

module wrol_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        req_type,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        found,
	input logic [wrol_pkg::HIDX_W-1:0] hit_index,
	input logic [wrol_pkg::TAG_W-1:0]  hit_tag,
	input logic [wrol_pkg::LEN_W-1:0]  hit_size,
	input logic [wrol_pkg::LEN_W-1:0]  byte_within,
	input logic                        ring_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(hit_tag)
			&& $stable(byte_within) && $stable(ring_full))
		else $error("result beat changed while stalled");

	a_add_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == wrol_pkg::REQ_ADD |=> out_valid && !found)
		else $error("add did not give a not-found beat next cycle");

	a_find_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == wrol_pkg::REQ_FIND |=> !out_valid && !in_ready)
		else $error("find beat appeared without a walk");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> hit_size != '0 && byte_within < hit_size)
		else $error("hit offset outside its entry");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> hit_index == '0 && hit_tag == '0 && hit_size == '0
			&& byte_within == '0)
		else $error("miss beat carries nonzero hit fields");

endmodule

bind write_ring_offset_lookup wrol_checker u_wrol_checker (.*);

FILE: test/tb_write_ring_offset_lookup.sv
`timescale 1ns / 1ps
// tb_write_ring_offset_lookup: self-checking bench for the write ring offset lookup
// block. A directed table runs first, then random add/find traffic checked against a
// behavioral ring predictor. Depends on wrol_pkg and write_ring_offset_lookup.

module tb_write_ring_offset_lookup;
	import wrol_pkg::*;

	localparam int NSLOT        = SLOTS_DEF;
	localparam int DIR_N        = 13;
	localparam int RAND_ITEMS   = 1640;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = NSLOT + 8;

	typedef struct packed {
		logic              found;
		logic [HIDX_W-1:0] index;
		logic [TAG_W-1:0]  tag;
		logic [LEN_W-1:0]  size;
		logic [LEN_W-1:0]  ofs;
		logic              full;
	} lookup_res_t;

	typedef struct packed {
		logic             req;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] size;
		logic [OFF_W-1:0] offset;
		logic             typed;
		lookup_res_t      res;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic [TAG_W-1:0]  entry_tag;
	logic [LEN_W-1:0]  entry_size;
	logic [OFF_W-1:0]  byte_pos;
	logic              out_valid;
	logic              out_ready;
	logic              found;
	logic [HIDX_W-1:0] hit_index;
	logic [TAG_W-1:0]  hit_tag;
	logic [LEN_W-1:0]  hit_size;
	logic [LEN_W-1:0]  byte_within;
	logic              ring_full;

	// predictor state
	logic [LEN_W-1:0] ring_len [NSLOT];
	logic [TAG_W-1:0] ring_tag [NSLOT];
	int unsigned      ring_wr;
	int unsigned      ring_rd;
	logic             ring_full_q;

	lookup_res_t pending_results[$];
	lookup_res_t exp_res;
	dir_row_t    dir_tab [DIR_N];

	int  errors;
	int  n_sent;
	int  n_results;
	int  n_adds;
	int  n_finds;
	int  n_hits;
	int  quiet_cycles;
	bit  steady;

	write_ring_offset_lookup uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.entry_tag  (entry_tag),
		.entry_size (entry_size),
		.byte_pos   (byte_pos),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.hit_index  (hit_index),
		.hit_tag    (hit_tag),
		.hit_size   (hit_size),
		.byte_within(byte_within),
		.ring_full  (ring_full)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lookup_res_t ring_apply(logic req, logic [TAG_W-1:0] tag,
			logic [LEN_W-1:0] size, logic [OFF_W-1:0] offset);
		lookup_res_t      r;
		logic [OFF_W-1:0] rem;
		int unsigned      i;
		int unsigned      idx;
		r   = '0;
		rem = offset;
		if (req == REQ_ADD) begin
			ring_tag[ring_wr] = tag;
			ring_len[ring_wr] = size;
			ring_wr = (ring_wr + 1) % NSLOT;
			if (ring_full_q)
				ring_rd = (ring_rd + 1) % NSLOT;
			else if (ring_wr == ring_rd)
				ring_full_q = 1'b1;
		end else begin
			for (i = 0; i < NSLOT; i++) begin
				idx = (ring_rd + i) % NSLOT;
				if (ring_len[idx] == '0)
					break;
				if (rem >= OFF_W'(ring_len[idx])) begin
					rem = rem - OFF_W'(ring_len[idx]);
				end else begin
					r.found = 1'b1;
					r.index = idx[HIDX_W-1:0];
					r.tag   = ring_tag[idx];
					r.size  = ring_len[idx];
					r.ofs   = rem[LEN_W-1:0];
					break;
				end
			end
		end
		r.full = ring_full_q;
		return r;
	endfunction

	// bytes held by the oldest live entries, up to the first empty slot
	function automatic int unsigned prefix_bytes(int unsigned count);
		int unsigned sum;
		int unsigned i;
		int unsigned idx;
		sum = 0;
		for (i = 0; i < count; i++) begin
			idx = (ring_rd + i) % NSLOT;
			if (ring_len[idx] == '0)
				break;
			sum += 32'(ring_len[idx]);
		end
		return sum;
	endfunction

	function automatic logic [OFF_W-1:0] pick_offset();
		int unsigned total;
		int unsigned p;
		total = prefix_bytes(NSLOT);
		case ($urandom_range(0, 9))
			0: return OFF_W'($urandom());
			1: return OFF_W'(total + $urandom_range(0, 3));
			2, 3, 4: begin
				p = prefix_bytes($urandom_range(1, NSLOT));
				if (p > 0 && $urandom_range(0, 1) == 1)
					p--;
				return OFF_W'(p);
			end
			default: begin
				if (total == 0)
					return OFF_W'($urandom_range(0, 15));
				return OFF_W'($urandom_range(0, total - 1));
			end
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_size();
		case ($urandom_range(0, 19))
			0:                   return '0;
			1, 2:                return '1;
			3, 4, 5, 6, 7, 8, 9: return LEN_W'($urandom_range(1, 8));
			default:             return LEN_W'($urandom_range(1, 16'hFFFF));
		endcase
	endfunction

	function automatic void check_field(string fname, logic [TAG_W-1:0] want,
			logic [TAG_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
			errors++;
		end
	endfunction

	task automatic send_request(input logic req, input logic [TAG_W-1:0] tag,
			input logic [LEN_W-1:0] size, input logic [OFF_W-1:0] offset,
			input logic typed, input lookup_res_t typed_res);
		lookup_res_t pred;
		pred = ring_apply(req, tag, size, offset);
		pending_results.push_back(typed ? typed_res : pred);
		if (req == REQ_ADD)
			n_adds++;
		else
			n_finds++;
		if (pred.found)
			n_hits++;
		if (!steady && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		entry_tag   <= tag;
		entry_size  <= size;
		byte_pos    <= offset;
		n_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		wait (n_results == n_sent);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 29);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, got found=%b",
					$time, found);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				check_field("found", TAG_W'(exp_res.found), TAG_W'(found));
				check_field("hit_index", TAG_W'(exp_res.index), TAG_W'(hit_index));
				check_field("hit_tag", exp_res.tag, hit_tag);
				check_field("hit_size", TAG_W'(exp_res.size), TAG_W'(hit_size));
				check_field("byte_within", TAG_W'(exp_res.ofs), TAG_W'(byte_within));
				check_field("ring_full", TAG_W'(exp_res.full), TAG_W'(ring_full));
			end
			n_results++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned burst;
		bit          max_burst;
		bit          pressured;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = REQ_ADD;
		entry_tag   = '0;
		entry_size  = '0;
		byte_pos    = '0;
		out_ready   = 1'b0;
		errors      = 0;
		n_sent      = 0;
		n_results   = 0;
		n_adds      = 0;
		n_finds     = 0;
		n_hits      = 0;
		quiet_cycles = 0;
		steady      = 1'b0;
		pressured   = 1'b0;
		ring_wr     = 0;
		ring_rd     = 0;
		ring_full_q = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			ring_len[i] = '0;
			ring_tag[i] = '0;
		end

		// typed rows: empty ring, single max entry, its edges, add results
		dir_tab[0]  = '{REQ_FIND, 32'h0, 16'h0, 20'h00000, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[1]  = '{REQ_FIND, 32'hFFFFFFFF, 16'hFFFF, 20'hFFFFF, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[2]  = '{REQ_ADD, 32'hFFFFFFFF, 16'hFFFF, 20'h00000, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[3]  = '{REQ_FIND, 32'h0, 16'h0, 20'h00000, 1'b1,
			'{1'b1, 4'h0, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 1'b0}};
		dir_tab[4]  = '{REQ_FIND, 32'h0, 16'h0, 20'h0FFFE, 1'b1,
			'{1'b1, 4'h0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFE, 1'b0}};
		dir_tab[5]  = '{REQ_FIND, 32'h0, 16'h0, 20'h0FFFF, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[6]  = '{REQ_ADD, 32'h0, 16'h0001, 20'hFFFFF, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[7]  = '{REQ_FIND, 32'h0, 16'h0, 20'h0FFFF, 1'b0, '0};
		dir_tab[8]  = '{REQ_FIND, 32'h0, 16'h0, 20'h10000, 1'b0, '0};
		// zero-length add: later walks must stop there
		dir_tab[9]  = '{REQ_ADD, 32'hA5A5A5A5, 16'h0000, 20'h0, 1'b1,
			'{1'b0, 4'h0, 32'h0, 16'h0, 16'h0, 1'b0}};
		dir_tab[10] = '{REQ_ADD, 32'h5A5A5A5A, 16'h0007, 20'h0, 1'b0, '0};
		dir_tab[11] = '{REQ_FIND, 32'h0, 16'h0, 20'h10001, 1'b0, '0};
		dir_tab[12] = '{REQ_FIND, 32'h0, 16'h0, 20'h00000, 1'b0, '0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_N; k++)
			send_request(dir_tab[k].req, dir_tab[k].tag, dir_tab[k].size,
				dir_tab[k].offset, dir_tab[k].typed, dir_tab[k].res);
		hold_until_drained();

		while (n_sent < DIR_N + RAND_ITEMS) begin
			if (!pressured && n_sent >= 400) begin
				hold_until_drained();
				pressured = 1'b1;
			end
			steady = (n_sent >= 700 && n_sent < 1000);
			if ($urandom_range(0, 9) < 4) begin
				burst     = $urandom_range(1, 20);
				max_burst = ($urandom_range(0, 7) == 0);
				repeat (burst)
					send_request(REQ_ADD, $urandom(), max_burst ? 16'hFFFF : pick_size(),
						OFF_W'($urandom()), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 8))
					send_request(REQ_FIND, $urandom(), LEN_W'($urandom()), pick_offset(),
						1'b0, '0);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		wait (n_results == n_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: results still outstanding: expected 0, got %0d", $time,
				pending_results.size());
			errors++;
		end

		$display("Sent %0d adds and %0d finds (%0d hits, %0d misses), %0d results checked.",
			n_adds, n_finds, n_hits, n_finds - n_hits, n_results);
		$display("Ring wrapped through overwrite with full flag %0s.",
			ring_full_q ? "set" : "never set");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/wrol_pkg.sv
rtl/core/write_ring_offset_lookup.sv
rtl/core/wrol_checker.sv
test/tb_write_ring_offset_lookup.sv
